FILE: design/tsdb_pkg.sv
// Shared types and constants for the timestamped sample delay buffer.
// Used by tsdb_cell, tsdb_search and timestamped_sample_delay_buffer.
`default_nettype none

package tsdb_pkg;

	// Number of entries in the ring of cells.
	localparam int unsigned DEPTH = 50;
	localparam int unsigned IDX_W = $clog2(DEPTH);

	// Only differences below this limit take part in the search.
	localparam logic [10:0] SEARCH_LIMIT = 11'd2000;

	// Register reset values.
	localparam logic [15:0] DELAY_RST  = 16'd0;
	localparam logic [9:0]  PERIOD_RST = 10'd10;
	localparam logic [10:0] WINDOW_RST = 11'd200;

	// Configuration register indexes.
	localparam logic [1:0] REG_DELAY  = 2'd0;
	localparam logic [1:0] REG_PERIOD = 2'd1;
	localparam logic [1:0] REG_WINDOW = 2'd2;

	// One stored entry: the time stamp and the three-axis sample.
	typedef struct packed {
		logic [31:0]        stamp;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} entry_t;

	// Control from the sequencer to the search unit.
	typedef struct packed {
		logic start;
		logic step;
	} search_ctl_t;

endpackage

`default_nettype wire

FILE: design/tsdb_cell.sv
// One cell of the rotating entry ring: holds a single stored entry.
// Depends on tsdb_pkg for the entry type.
`default_nettype none

module tsdb_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              shift,
	input  wire tsdb_pkg::entry_t  d,
	output tsdb_pkg::entry_t       q
);

	tsdb_pkg::entry_t entry_q;

	// The entry moves one place toward the head on every shift.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

`default_nettype wire

FILE: design/tsdb_search.sv
// Nearest-match tracker: keeps the best entry seen during one ring rotation.
// Depends on tsdb_pkg for the entry and control types.
`default_nettype none

module tsdb_search (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire tsdb_pkg::search_ctl_t ctl,
	input  wire logic [31:0]           target,
	input  wire tsdb_pkg::entry_t      cand,
	output logic                       found,
	output logic [10:0]                best_diff,
	output tsdb_pkg::entry_t           best
);

	logic [31:0]      diff;
	logic             better;
	logic             found_q;
	logic [10:0]      best_diff_q;
	tsdb_pkg::entry_t best_q;

	// Modulo-2^32 distance from the candidate stamp to the target time.
	assign diff   = target - cand.stamp;
	// Strict compare, so the entry seen first keeps a tie.
	assign better = (diff < {21'd0, best_diff_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= 1'b0;
			best_diff_q <= tsdb_pkg::SEARCH_LIMIT;
		end else if (ctl.start) begin
			found_q     <= 1'b0;
			best_diff_q <= tsdb_pkg::SEARCH_LIMIT;
		end else if (ctl.step && better) begin
			found_q     <= 1'b1;
			best_diff_q <= diff[10:0];
		end
	end

	// The winning sample travels with the search, so no read-back is needed.
	always_ff @(posedge clk) begin
		if (ctl.step && better) begin
			best_q <= cand;
		end
	end

	assign found     = found_q;
	assign best_diff = best_diff_q;
	assign best      = best_q;

endmodule

`default_nettype wire

FILE: design/timestamped_sample_delay_buffer.sv
// Timestamped sample delay buffer: usage notes
// Input channel (in_valid / in_stall) carries a millisecond time and a
// three-axis sample. Output channel (out_valid / out_stall) carries the held
// delayed sample and a matched flag; every input transaction yields exactly
// one output transaction. Registers are written through wr_en / wr_index /
// wr_data; the user must do so only while the block is idle (not enforced).
// Entries live in a ring of DEPTH cells that rotates one place per cycle
// during a scan. A transaction runs one rotation of the ring, which brings
// every entry past the comparator at the head, then loads the result in
// S_DONE, where it waits while the output register is full and stalled. The
// next transaction is accepted only back in S_IDLE, so transactions do not
// overlap; this is set by the single comparator at the ring head.
// A finished result sits in the output register; the next input can be
// accepted while it waits. If the receiver still stalls when the following
// result is ready, the block holds that result and keeps in_stall high.
// Reset clears all entries, the write index, the last store time, the held
// sample and the registers to their defaults; no clearing pass is needed.
// Depends on tsdb_pkg, tsdb_cell and tsdb_search.
`default_nettype none

module timestamped_sample_delay_buffer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// Configuration port.
	input  wire logic               wr_en,
	input  wire logic [1:0]         wr_index,
	input  wire logic [15:0]        wr_data,
	// Input channel.
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [31:0]        now_ms,
	input  wire logic signed [15:0] sample_x,
	input  wire logic signed [15:0] sample_y,
	input  wire logic signed [15:0] sample_z,
	// Output channel.
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      delayed_x,
	output logic signed [15:0]      delayed_y,
	output logic signed [15:0]      delayed_z,
	output logic                    matched
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	localparam logic [tsdb_pkg::IDX_W-1:0] LAST_IDX = tsdb_pkg::IDX_W'(tsdb_pkg::DEPTH - 1);

	state_t                       state_q;
	logic [tsdb_pkg::IDX_W-1:0]   step_q;
	logic [tsdb_pkg::IDX_W-1:0]   write_index_q;
	logic [tsdb_pkg::IDX_W-1:0]   wsel_q;
	logic                         store_q;
	logic [31:0]                  last_store_q;
	logic [31:0]                  target_q;
	tsdb_pkg::entry_t             new_entry_q;
	tsdb_pkg::entry_t             held_q;
	logic                         matched_q;
	logic                         out_valid_q;

	logic [15:0]                  delay_q;
	logic [9:0]                   period_q;
	logic [10:0]                  window_q;

	logic                         in_accept;
	logic                         do_store;
	logic                         shift;
	logic                         load_out;
	logic                         update;
	tsdb_pkg::entry_t             head_val;
	tsdb_pkg::entry_t             cell_q [tsdb_pkg::DEPTH];
	tsdb_pkg::search_ctl_t        sctl;
	logic                         found;
	logic [10:0]                  best_diff;
	tsdb_pkg::entry_t             best;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q  <= tsdb_pkg::DELAY_RST;
			period_q <= tsdb_pkg::PERIOD_RST;
			window_q <= tsdb_pkg::WINDOW_RST;
		end else if (wr_en) begin
			case (wr_index)
				tsdb_pkg::REG_DELAY:  delay_q  <= wr_data;
				tsdb_pkg::REG_PERIOD: period_q <= wr_data[9:0];
				tsdb_pkg::REG_WINDOW: window_q <= wr_data[10:0];
				default: ;
			endcase
		end
	end

	// Handshake and store decision.
	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign do_store  = ((now_ms - last_store_q) >= {22'd0, period_q});
	assign shift     = (state_q == S_SCAN);
	assign load_out  = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign update    = found && (best_diff < window_q);

	// The entry at the head is replaced by the new sample when its turn comes.
	assign head_val = (store_q && (step_q == wsel_q)) ? new_entry_q : cell_q[0];

	// Ring of cells: each hands its entry to the one nearer the head.
	for (genvar g = 0; g < tsdb_pkg::DEPTH; g++) begin : g_ring
		if (g == tsdb_pkg::DEPTH - 1) begin : g_tail
			tsdb_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.d      (head_val),
				.q      (cell_q[g])
			);
		end else begin : g_body
			tsdb_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.d      (cell_q[g+1]),
				.q      (cell_q[g])
			);
		end
	end

	// Search unit sees each entry once per rotation, in index order.
	assign sctl.start = in_accept;
	assign sctl.step  = shift;

	tsdb_search u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (sctl),
		.target    (target_q),
		.cand      (head_val),
		.found     (found),
		.best_diff (best_diff),
		.best      (best)
	);

	// Sequencer, store bookkeeping and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			step_q        <= '0;
			write_index_q <= '0;
			wsel_q        <= '0;
			store_q       <= 1'b0;
			last_store_q  <= '0;
			held_q        <= '0;
			matched_q     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			// A new result takes the output register; otherwise it empties once taken.
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						store_q <= do_store;
						wsel_q  <= write_index_q;
						if (do_store) begin
							last_store_q  <= now_ms;
							write_index_q <= (write_index_q == LAST_IDX) ? '0
								: write_index_q + 1'b1;
						end
						step_q  <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (step_q == LAST_IDX) begin
						step_q  <= '0;
						state_q <= S_DONE;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_DONE: begin
					if (load_out) begin
						if (update) begin
							held_q <= best;
						end
						matched_q <= update;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Transaction payload captured at acceptance.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			target_q          <= now_ms - {16'd0, delay_q};
			new_entry_q.stamp <= now_ms;
			new_entry_q.x     <= sample_x;
			new_entry_q.y     <= sample_y;
			new_entry_q.z     <= sample_z;
		end
	end

	assign out_valid = out_valid_q;
	assign delayed_x = held_q.x;
	assign delayed_y = held_q.y;
	assign delayed_z = held_q.z;
	assign matched   = matched_q;

	// An accepted transaction always starts a rotation.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q == S_SCAN && step_q == '0))
		else $error("accepted transaction did not start a scan");

	// The step counter only runs during a rotation.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_SCAN) |-> (step_q == '0))
		else $error("step counter moved outside a scan");

	// The write index stays inside the ring.
	assert property (@(posedge clk) disable iff (!arst_n)
		(write_index_q <= LAST_IDX))
		else $error("write index out of range");

	// A match only ever reports a found candidate with a distance below the search limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		load_out && update |-> (found && best_diff < tsdb_pkg::SEARCH_LIMIT))
		else $error("match reported without a valid candidate");

endmodule

`default_nettype wire
